@@ src/pfc_pkg.sv @@
`default_nettype none

package pfc_pkg;

	localparam int unsigned CompWidth  = 8;
	localparam int unsigned PixelWidth = 32;
	localparam int unsigned CfgWidth   = 24;
	localparam int unsigned CfgIdxWidth = 2;

	// Configuration register indexes
	localparam logic [CfgIdxWidth-1:0] REG_COMP_COUNT = 2'd0;
	localparam logic [CfgIdxWidth-1:0] REG_KEY_ENABLE = 2'd1;
	localparam logic [CfgIdxWidth-1:0] REG_KEY_COLOR  = 2'd2;
	localparam logic [CfgIdxWidth-1:0] REG_OUT_FORMAT = 2'd3;

	// Source component counts
	localparam logic [2:0] COUNT_GRAY       = 3'd1;
	localparam logic [2:0] COUNT_GRAY_ALPHA = 3'd2;
	localparam logic [2:0] COUNT_RGB        = 3'd3;
	localparam logic [2:0] COUNT_RGBA       = 3'd4;

	// Output formats
	localparam logic [2:0] FMT_RGBA8888 = 3'd0;
	localparam logic [2:0] FMT_RGB888   = 3'd1;
	localparam logic [2:0] FMT_RGB565   = 3'd2;
	localparam logic [2:0] FMT_RGBA4444 = 3'd3;
	localparam logic [2:0] FMT_RGBA5551 = 3'd4;
	localparam logic [2:0] FMT_MASK     = 3'd5;

	localparam logic [2:0]  RESET_COMP_COUNT = COUNT_RGBA;
	localparam logic [2:0]  RESET_OUT_FORMAT = FMT_RGBA8888;
	localparam logic [7:0]  CHAN_FULL        = 8'hff;
	localparam logic [23:0] MASK_RGB_WHITE   = 24'hff_ffff;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
	} rgba_t;

	function automatic logic [PixelWidth-1:0] pack_pixel(input logic [2:0] fmt, input rgba_t p);
		logic [PixelWidth-1:0] res;
		case (fmt)
			FMT_RGB888:   res = {8'h00, p.b, p.g, p.r};
			FMT_RGB565:   res = {16'h0000, p.r[7:3], p.g[7:2], p.b[7:3]};
			FMT_RGBA4444: res = {16'h0000, p.r[7:4], p.g[7:4], p.b[7:4], p.a[7:4]};
			FMT_RGBA5551: res = {16'h0000, p.r[7:3], p.g[7:3], p.b[7:3], p.a[7]};
			FMT_MASK:     res = {~p.b, MASK_RGB_WHITE};
			default:      res = {p.a, p.b, p.g, p.r};
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

@@ src/pixel_format_converter.sv @@
`default_nettype none

// Pixel format converter. Each request on the slave stream carries one source pixel of up
// to four component bytes (comp0 in tdata[7:0] up to comp3 in tdata[31:24]); the block
// expands it to RGBA by the configured component count (gray, gray+alpha, RGB, RGBA,
// missing channels at 255, unused counts give opaque white), optionally clears alpha
// when RGB matches the color key, and packs it into the selected output format. Exactly
// one master-stream request leaves for every slave request, in order. The block takes a
// pixel every cycle: an input register and an output register sit around one short stage
// of bit selection and a 24-bit compare; a pixel passes both registers before tvalid
// rises, and throughput is one pixel per clock while the downstream side keeps tready high. Write
// configuration registers only while no pixel is in flight.
module pixel_format_converter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data,
	// source pixels
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // comp0 [7:0], comp1 [15:8], comp2 [23:16], comp3 [31:24]
	// packed pixels
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata    // packed_pixel [31:0]
);

	// Configuration registers
	logic [2:0]  comp_count_q;
	logic        key_enable_q;
	logic [23:0] key_color_q;
	logic [2:0]  out_format_q;

	// Input register and output register
	logic        valid_s1;
	logic [31:0] comps_s1;
	logic        valid_s2;
	logic [31:0] pixel_s2;

	logic        advance_s2;
	logic        advance_s1;
	pfc_pkg::rgba_t expanded;
	pfc_pkg::rgba_t keyed;
	logic [7:0]  c0, c1, c2, c3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_count_q <= pfc_pkg::RESET_COMP_COUNT;
			key_enable_q <= 1'b0;
			key_color_q  <= '0;
			out_format_q <= pfc_pkg::RESET_OUT_FORMAT;
		end else if (cfg_we) begin
			case (cfg_index)
				pfc_pkg::REG_COMP_COUNT: comp_count_q <= cfg_data[2:0];
				pfc_pkg::REG_KEY_ENABLE: key_enable_q <= cfg_data[0];
				pfc_pkg::REG_KEY_COLOR:  key_color_q  <= cfg_data;
				pfc_pkg::REG_OUT_FORMAT: out_format_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// The output register frees when empty or taken; the input register then moves on,
	// so a new pixel enters while a finished one still waits downstream.
	assign advance_s2    = !valid_s2 || m_axis_tready;
	assign advance_s1    = valid_s1 && advance_s2;
	assign s_axis_tready = !valid_s1 || advance_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (advance_s2)
				valid_s2 <= valid_s1;
		end
	end

	// Payload registers: no reset needed
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			comps_s1 <= s_axis_tdata;
		if (advance_s1)
			pixel_s2 <= pfc_pkg::pack_pixel(out_format_q, keyed);
	end

	assign c0 = comps_s1[7:0];
	assign c1 = comps_s1[15:8];
	assign c2 = comps_s1[23:16];
	assign c3 = comps_s1[31:24];

	// Expand to RGBA; channels not supplied read as full scale
	always_comb begin
		expanded = {pfc_pkg::CHAN_FULL, pfc_pkg::CHAN_FULL,
			pfc_pkg::CHAN_FULL, pfc_pkg::CHAN_FULL};
		case (comp_count_q)
			pfc_pkg::COUNT_GRAY: begin
				expanded.r = c0;
				expanded.g = c0;
				expanded.b = c0;
			end
			pfc_pkg::COUNT_GRAY_ALPHA: begin
				expanded.r = c0;
				expanded.g = c0;
				expanded.b = c0;
				expanded.a = c1;
			end
			pfc_pkg::COUNT_RGB: begin
				expanded.r = c0;
				expanded.g = c1;
				expanded.b = c2;
			end
			pfc_pkg::COUNT_RGBA: begin
				expanded.r = c0;
				expanded.g = c1;
				expanded.b = c2;
				expanded.a = c3;
			end
			default: ;
		endcase
	end

	// Color key: drop alpha to zero on an exact RGB match
	always_comb begin
		keyed = expanded;
		if (key_enable_q && ({expanded.r, expanded.g, expanded.b} == key_color_q))
			keyed.a = 8'h00;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = pixel_s2;

	// An empty output register never blocks the input side
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_axis_tready)
		else $error("input stalled with empty output register");

	// A pixel in the input register reaches the output when the output register is free
	a_s1_moves_on: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !valid_s2) |=> valid_s2)
		else $error("pixel lost between input and output register");

	// With both registers full and downstream stalled, no new pixel is taken
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_axis_tready) |-> !s_axis_tready)
		else $error("pixel accepted while pipeline is full");

endmodule

`default_nettype wire

@@ tb/sv/pfc_checker.sv @@
`timescale 1ns / 1ps

module pfc_checker
	import pfc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [31:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [31:0] m_tdata,
	output int               mismatches,
	output int               outstanding
);

	logic [2:0]  comp_count;
	logic        key_on;
	logic [23:0] key_rgb;
	logic [2:0]  out_fmt;
	logic [31:0] pending_pixels [$];

	// Expand one source pixel to RGBA, apply the color key, pack by format.
	function automatic logic [31:0] convert_pixel(input logic [31:0] src);
		logic [7:0]  red, grn, blu, alf;
		logic [31:0] word;
		red = CHAN_FULL;
		grn = CHAN_FULL;
		blu = CHAN_FULL;
		alf = CHAN_FULL;
		case (comp_count)
			COUNT_GRAY: begin
				red = src[7:0];
				grn = src[7:0];
				blu = src[7:0];
			end
			COUNT_GRAY_ALPHA: begin
				red = src[7:0];
				grn = src[7:0];
				blu = src[7:0];
				alf = src[15:8];
			end
			COUNT_RGB: begin
				red = src[7:0];
				grn = src[15:8];
				blu = src[23:16];
			end
			COUNT_RGBA: begin
				red = src[7:0];
				grn = src[15:8];
				blu = src[23:16];
				alf = src[31:24];
			end
			default: ;
		endcase
		if (key_on && red == key_rgb[23:16] && grn == key_rgb[15:8] && blu == key_rgb[7:0])
			alf = 8'h00;
		word = '0;
		case (out_fmt)
			FMT_RGB888: word[23:0] = {blu, grn, red};
			FMT_RGB565: word[15:0] = {red[7:3], grn[7:2], blu[7:3]};
			FMT_RGBA4444: word[15:0] = {red[7:4], grn[7:4], blu[7:4], alf[7:4]};
			FMT_RGBA5551: word[15:0] = {red[7:3], grn[7:3], blu[7:3], alf[7]};
			FMT_MASK: word = {CHAN_FULL - blu, 24'hff_ffff};
			default: word = {alf, blu, grn, red};
		endcase
		return word;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want;
		if (!arst_n) begin
			comp_count = RESET_COMP_COUNT;
			key_on = 1'b0;
			key_rgb = '0;
			out_fmt = RESET_OUT_FORMAT;
			pending_pixels.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_COMP_COUNT: comp_count = cfg_data[2:0];
					REG_KEY_ENABLE: key_on = cfg_data[0];
					REG_KEY_COLOR:  key_rgb = cfg_data;
					REG_OUT_FORMAT: out_fmt = cfg_data[2:0];
					default: ;
				endcase
			end
			// retire the oldest pixel before queuing a new one
			if (m_tvalid && m_tready) begin
				if (pending_pixels.size() == 0) begin
					$display("%0t: unexpected packed pixel, expected none, actual %08h",
						$time, m_tdata);
					mismatches++;
				end else begin
					want = pending_pixels.pop_front();
					if (m_tdata !== want) begin
						$display("%0t: packed_pixel mismatch, expected %08h, actual %08h",
							$time, want, m_tdata);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready)
				pending_pixels.push_back(convert_pixel(s_tdata));
			outstanding = pending_pixels.size();
		end
	end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import pfc_pkg::*;

	// encodings the package leaves unnamed
	localparam logic [2:0] COUNT_NONE    = 3'd0;
	localparam logic [2:0] COUNT_SPARE   = 3'd5;
	localparam logic [2:0] COUNT_TOP     = 3'd7;
	localparam logic [2:0] FMT_SPARE_LO  = 3'd6;
	localparam logic [2:0] FMT_SPARE_HI  = 3'd7;
	localparam int         PHASES        = 29;
	localparam int         PHASE_PIXELS  = 50;
	localparam int         SETTLE_CYCLES = 4;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic [1:0]  cfg_index     = '0;
	logic [23:0] cfg_data      = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;   // comp0 [7:0], comp1 [15:8], comp2 [23:16], comp3 [31:24]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;         // packed_pixel [31:0]
	logic        calm          = 1'b0; // suppress idling on both sides
	int          mismatches;
	int          outstanding;

	pixel_format_converter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	pfc_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs or drops a request.
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	// Pick a per-request wait; calm stretches run back to back.
	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 6);
	endfunction

	// Downstream side: stall a random number of cycles, then take one request.
	initial begin : sink
		int stall;
		wait (arst_n);
		forever begin
			stall = draw_gap();
			@(negedge clk);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Write one register; the enable drops at the next falling edge.
	task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_config(input logic [2:0] count, input logic key_en,
			input logic [23:0] key, input logic [2:0] fmt);
		write_reg(REG_COMP_COUNT, {21'd0, count});
		write_reg(REG_KEY_ENABLE, {23'd0, key_en});
		write_reg(REG_KEY_COLOR, key);
		write_reg(REG_OUT_FORMAT, {21'd0, fmt});
	endtask

	// Offer one source pixel after a random gap and hold it until accepted.
	// tvalid stays high after acceptance so back-to-back requests never
	// lower and raise it within one time step.
	task automatic send_pixel(input logic [31:0] pixel);
		int gap;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pixel;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Drop the request line and hold off until every packed pixel is back,
	// then let the pipeline settle before touching the registers.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin : stimulus
		logic [2:0]  count;
		logic        key_en;
		logic [23:0] key;
		logic [2:0]  fmt;
		logic [31:0] pixel;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed: reset settings (RGBA in, RGBA8888 out), field extremes.
		send_pixel(32'h0000_0000);
		send_pixel(32'hffff_ffff);
		send_pixel(32'h8040_2010);
		drain();

		// Directed: every output format but RGBA8888, unused ones included.
		set_config(COUNT_RGBA, 1'b0, 24'h00_0000, FMT_RGB888);
		send_pixel(32'h00ff_00ff);
		drain();
		set_config(COUNT_RGBA, 1'b0, 24'h00_0000, FMT_RGB565);
		send_pixel(32'hff00_ff00);
		drain();
		set_config(COUNT_RGBA, 1'b0, 24'h00_0000, FMT_RGBA4444);
		send_pixel(32'h5a3c_c3a5);
		drain();
		set_config(COUNT_RGBA, 1'b0, 24'h00_0000, FMT_RGBA5551);
		send_pixel(32'h80f8_07f8);
		drain();
		// mask: blue at both ends
		set_config(COUNT_RGBA, 1'b0, 24'h00_0000, FMT_MASK);
		send_pixel(32'h1200_3456);
		send_pixel(32'h12ff_3456);
		drain();
		set_config(COUNT_RGBA, 1'b0, 24'h00_0000, FMT_SPARE_LO);
		send_pixel(32'hc3a5_5a3c);
		drain();
		set_config(COUNT_RGBA, 1'b0, 24'h00_0000, FMT_SPARE_HI);
		send_pixel(32'h3c5a_a5c3);
		drain();

		// Directed: gray, gray+alpha, RGB and unused component counts.
		set_config(COUNT_NONE, 1'b0, 24'h00_0000, FMT_RGBA8888);
		send_pixel(32'hc3a5_5a3c);
		drain();
		set_config(COUNT_GRAY, 1'b0, 24'h00_0000, FMT_RGBA8888);
		send_pixel(32'hc3a5_5a3c);
		drain();
		set_config(COUNT_GRAY_ALPHA, 1'b0, 24'h00_0000, FMT_RGBA8888);
		send_pixel(32'hc3a5_5a3c);
		drain();
		set_config(COUNT_RGB, 1'b0, 24'h00_0000, FMT_RGBA8888);
		send_pixel(32'hc3a5_5a3c);
		drain();
		set_config(COUNT_TOP, 1'b0, 24'h00_0000, FMT_RGBA8888);
		send_pixel(32'hc3a5_5a3c);
		drain();

		// Directed: color key hit and near miss, gray key, key hidden by an
		// alpha-less format, and white from an unused count hitting a white key.
		set_config(COUNT_RGB, 1'b1, 24'h12_3456, FMT_RGBA4444);
		send_pixel(32'hff56_3412);
		send_pixel(32'hff56_3413);
		drain();
		set_config(COUNT_GRAY, 1'b1, 24'h77_7777, FMT_RGBA8888);
		send_pixel(32'h0000_0077);
		drain();
		set_config(COUNT_RGB, 1'b1, 24'h12_3456, FMT_RGB888);
		send_pixel(32'hff56_3412);
		drain();
		set_config(COUNT_SPARE, 1'b1, 24'hff_ffff, FMT_RGBA5551);
		send_pixel($urandom);
		drain();

		// Random phases: fresh settings each time, a quarter of the keyed
		// pixels steered onto the key so the compare hits often.
		for (int phase = 0; phase < PHASES; phase++) begin
			count  = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
				: 3'($urandom_range(COUNT_RGBA, COUNT_GRAY));
			key_en = 1'($urandom_range(0, 1));
			fmt    = 3'($urandom_range(0, 7));
			case (phase)
				0: key = 24'h00_0000;
				1: key = 24'hff_ffff;
				default: begin
					case ($urandom_range(0, 2))
						0: key = 24'($urandom);
						1: key = {3{8'($urandom)}};
						default: key = 24'hff_ffff;
					endcase
				end
			endcase
			if (phase == 2)
				fmt = FMT_MASK;
			set_config(count, key_en, key, fmt);
			calm = (phase % 4 == 0);
			for (int n = 0; n < PHASE_PIXELS; n++) begin
				pixel = $urandom;
				if (key_en && $urandom_range(0, 3) == 0) begin
					if (count == COUNT_RGB || count == COUNT_RGBA)
						pixel[23:0] = {key[7:0], key[15:8], key[23:16]};
					else
						pixel[7:0] = key[7:0];
				end
				send_pixel(pixel);
			end
			// pause until every packed pixel of this phase is back
			drain();
		end
		calm = 1'b0;

		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/pfc_pkg.sv
src/pixel_format_converter.sv
tb/sv/pfc_checker.sv
tb/sv/tb_top.sv
